// File: design/tsi_pkg.sv
// Shared types and constants for the timestamped snapshot interpolator.
package tsi_pkg;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_MAXSMP = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  localparam logic signed [20:0] ANG_HALF   = 21'sd11520;
  localparam logic signed [20:0] ANG_FULL   = 21'sd23040;
  localparam logic [17:0]        ALPHA_HALF = 18'd32768;
  localparam logic [17:0]        ALPHA_MAX  = 18'd131072;
  localparam int                 ALPHA_BITS = 18;

  typedef struct packed {
    logic [31:0]        tm;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [14:0] ang;
  } tsi_sample_t;

  typedef struct packed {
    logic adv;
    logic wr;
  } tsi_ctrl_t;

endpackage

// File: design/tsi_cell.sv
// One sample cell of the ring chain; advances toward the head or takes a write.
module tsi_cell
  import tsi_pkg::*;
#(
  parameter int IW = 4,
  parameter logic [IW-1:0] IDX = '0
) (
  input  logic        clk,
  input  tsi_ctrl_t   ctrl,
  input  logic [IW-1:0] last_idx,
  input  logic [IW-1:0] wr_idx,
  input  tsi_sample_t nxt_in,
  input  tsi_sample_t head_in,
  input  tsi_sample_t wr_data,
  output tsi_sample_t q
);

  tsi_sample_t q_r;

  // The last occupied cell takes the head, so an advance rotates the held samples.
  always_ff @(posedge clk) begin
    if (ctrl.wr && (wr_idx == IDX)) begin
      q_r <= wr_data;
    end else if (ctrl.adv) begin
      q_r <= (IDX == last_idx) ? head_in : nxt_in;
    end
  end

  assign q = q_r;

endmodule

// File: design/tsi_alpha_div.sv
// Blend factor unit: restoring division of the time offset by the pair span.
module tsi_alpha_div
  import tsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] t0,
  input  logic [31:0] t1,
  input  logic [31:0] target,
  output logic        done,
  output logic [ALPHA_BITS-1:0] alpha
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state_r;
  logic [4:0]  step_r;
  logic [34:0] rem_r;
  logic [31:0] span_r;
  logic [ALPHA_BITS-1:0] quo_r;
  logic [ALPHA_BITS-1:0] alpha_r;
  logic        done_r;

  logic [31:0] span_nxt;
  logic [31:0] off_nxt;
  logic [34:0] rem_sh;
  logic [34:0] cmp_v;
  logic        bit_v;
  logic [ALPHA_BITS-1:0] quo_nxt;

  always_comb begin
    span_nxt = t1 - t0;
    off_nxt  = target - t0;
    // The first two steps form the integer part, the rest the sixteen fraction bits.
    rem_sh   = (step_r < 5'd2) ? rem_r : {rem_r[33:0], 1'b0};
    cmp_v    = (step_r == 5'd0) ? {2'b00, span_r, 1'b0} : {3'b000, span_r};
    bit_v    = (rem_sh >= cmp_v);
    quo_nxt  = {quo_r[ALPHA_BITS-2:0], bit_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (t1 == t0) begin
              alpha_r <= ALPHA_HALF;
              done_r  <= 1'b1;
            end else if ((t1 < t0) || (target < t0)) begin
              alpha_r <= '0;
              done_r  <= 1'b1;
            end else if ((off_nxt >> 2) >= span_nxt) begin
              alpha_r <= ALPHA_MAX;
              done_r  <= 1'b1;
            end else begin
              rem_r   <= {3'b000, off_nxt};
              span_r  <= span_nxt;
              quo_r   <= '0;
              step_r  <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rem_r  <= bit_v ? (rem_sh - cmp_v) : rem_sh;
          quo_r  <= quo_nxt;
          step_r <= step_r + 5'd1;
          if (step_r == 5'(ALPHA_BITS - 1)) begin
            alpha_r <= (quo_nxt > ALPHA_MAX) ? ALPHA_MAX : quo_nxt;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign alpha = alpha_r;

endmodule

// File: design/timestamped_snapshot_interpolator.sv
// Push: drops the oldest samples while the ring is at its limit, then writes. Query with
// an empty ring, one sample or interpolation off: result strobes the cycle after start.
// Otherwise busy through prune, trim, a ring rotation scan of the held samples, the
// divider (no division when alpha needs none), multiply and sum, then the result strobes.
// One transaction at a time; busy is low again in the cycle the result is strobed.
// Synchronous active-low reset empties the ring and loads register defaults;
// the receiver cannot stall, so each result is shown for exactly one cycle.
module timestamped_snapshot_interpolator
  import tsi_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [31:0]        in_time_ms,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [14:0] in_angle,
  output logic               out_strobe,
  output logic               out_valid,
  output logic               out_interpolated,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [14:0] out_angle,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_PRUNE, S_TRIM, S_SCAN, S_DIV, S_MUL, S_SUM
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] step_r;
  logic [15:0]   delay_r;
  logic [4:0]    maxs_r;
  logic          en_r;
  logic [31:0]   target_r;
  logic [31:0]   bound_r;
  logic          found_r;
  logic          before_r;
  tsi_sample_t   pa_r, pb_r, wr_r;
  logic          div_start_r;

  logic          ostb_r, oval_r, oint_r;
  logic signed [31:0] ox_r, oy_r;
  logic signed [14:0] oa_r;

  logic signed [51:0] px_r, py_r;
  logic signed [35:0] pang_r;

  tsi_sample_t   cell_q [RING_DEPTH];
  tsi_ctrl_t     ctrl;
  logic [IW-1:0] last_idx, wr_idx;

  logic [LW-1:0] ms_ext, lim_ext;
  logic [CW-1:0] lim;
  logic          div_done;
  logic [ALPHA_BITS-1:0] alpha;

  logic [31:0] target_nxt;
  logic [16:0] twice;
  logic        match;
  tsi_sample_t newest;

  logic signed [32:0] dx, dy;
  logic signed [16:0] dang;
  logic signed [35:0] sx, sy;
  logic signed [20:0] sang;
  logic signed [ALPHA_BITS:0] alpha_s;

  always_comb begin
    ms_ext  = LW'(maxs_r);
    if (ms_ext < LW'(2)) begin
      lim_ext = LW'(2);
    end else if (ms_ext > LW'(RING_DEPTH)) begin
      lim_ext = LW'(RING_DEPTH);
    end else begin
      lim_ext = ms_ext;
    end
    lim = lim_ext[CW-1:0];
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      S_PUSH:  begin
        ctrl.adv = (cnt_r >= lim);
        ctrl.wr  = (cnt_r < lim);
      end
      S_PRUNE: ctrl.adv = (cnt_r > CW'(3)) && (cell_q[0].tm < bound_r);
      S_TRIM:  ctrl.adv = (cnt_r > lim);
      S_SCAN:  ctrl.adv = 1'b1;
      default: ctrl = '0;
    endcase
  end

  assign last_idx = IW'(cnt_r - CW'(1));
  assign wr_idx   = IW'(cnt_r);

  genvar gi;
  generate
    for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
      tsi_cell #(.IW(IW), .IDX(IW'(gi))) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .last_idx (last_idx),
        .wr_idx   (wr_idx),
        .nxt_in   (cell_q[(gi + 1) % RING_DEPTH]),
        .head_in  (cell_q[0]),
        .wr_data  (wr_r),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  tsi_alpha_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start_r),
    .t0     (pa_r.tm),
    .t1     (pb_r.tm),
    .target (target_r),
    .done   (div_done),
    .alpha  (alpha)
  );

  always_comb begin
    target_nxt = (in_time_ms > {16'd0, delay_r}) ? (in_time_ms - {16'd0, delay_r}) : 32'd0;
    twice      = {delay_r, 1'b0};
    newest     = cell_q[IW'(cnt_r - CW'(1))];
    // During the scan the head cell holds sample step_r and its neighbor the next one.
    match      = (step_r < cnt_r - CW'(1)) && (cell_q[0].tm <= target_r) &&
                 (cell_q[1].tm >= target_r);
  end

  always_comb begin
    alpha_s = $signed({1'b0, alpha});
    dx   = $signed({pb_r.px[31], pb_r.px}) - $signed({pa_r.px[31], pa_r.px});
    dy   = $signed({pb_r.py[31], pb_r.py}) - $signed({pa_r.py[31], pa_r.py});
    dang = 17'($signed(pb_r.ang)) - 17'($signed(pa_r.ang));
    if (dang > 17'(ANG_HALF)) begin
      dang = dang - 17'(ANG_FULL);
    end
    if (dang < -17'(ANG_HALF)) begin
      dang = dang + 17'(ANG_FULL);
    end
    sx = 36'($signed(pa_r.px)) + px_r[51:16];
    sy = 36'($signed(pa_r.py)) + py_r[51:16];
    sang = 21'($signed(pa_r.ang)) + 21'($signed(pang_r[35:16]));
    for (int k = 0; k < 3; k++) begin
      if (sang > ANG_HALF) begin
        sang = sang - ANG_FULL;
      end else if (sang < -ANG_HALF) begin
        sang = sang + ANG_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      delay_r     <= 16'd100;
      maxs_r      <= 5'd16;
      en_r        <= 1'b1;
      ostb_r      <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      ostb_r      <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_DELAY:  delay_r <= cfg_wdata;
          REG_MAXSMP: maxs_r  <= cfg_wdata[4:0];
          REG_ENABLE: en_r    <= cfg_wdata[0];
          default:    ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_func == FUNC_PUSH) begin
              wr_r    <= '{tm: in_time_ms, px: in_pos_x, py: in_pos_y, ang: in_angle};
              state_r <= S_PUSH;
            end else if (cnt_r == '0) begin
              ostb_r <= 1'b1;
              oval_r <= 1'b0;
              oint_r <= 1'b0;
              ox_r   <= '0;
              oy_r   <= '0;
              oa_r   <= '0;
            end else if (!en_r || (cnt_r < CW'(2))) begin
              ostb_r <= 1'b1;
              oval_r <= 1'b1;
              oint_r <= 1'b0;
              ox_r   <= newest.px;
              oy_r   <= newest.py;
              oa_r   <= newest.ang;
            end else begin
              target_r <= target_nxt;
              bound_r  <= (target_nxt > {15'd0, twice}) ?
                          (target_nxt - {15'd0, twice}) : 32'd0;
              state_r  <= S_PRUNE;
            end
          end
        end
        S_PUSH: begin
          if (cnt_r >= lim) begin
            cnt_r <= cnt_r - CW'(1);
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_IDLE;
          end
        end
        S_PRUNE: begin
          if (ctrl.adv) begin
            cnt_r <= cnt_r - CW'(1);
          end else begin
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (ctrl.adv) begin
            cnt_r <= cnt_r - CW'(1);
          end else begin
            step_r  <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (match && !found_r) begin
            pa_r    <= cell_q[0];
            pb_r    <= cell_q[1];
            found_r <= 1'b1;
          end else if (step_r == '0) begin
            pa_r     <= cell_q[0];
            pb_r     <= cell_q[1];
            before_r <= (target_r < cell_q[0].tm);
          end else if ((step_r == cnt_r - CW'(2)) && !found_r && !before_r) begin
            pa_r <= cell_q[0];
            pb_r <= cell_q[1];
          end
          step_r <= step_r + CW'(1);
          // A full rotation restores the oldest-first order of the chain.
          if (step_r == cnt_r - CW'(1)) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= dx * alpha_s;
          py_r    <= dy * alpha_s;
          pang_r  <= 36'(dang * alpha_s);
          state_r <= S_SUM;
        end
        S_SUM: begin
          ostb_r <= 1'b1;
          oval_r <= 1'b1;
          oint_r <= 1'b1;
          ox_r   <= (sx > 36'sd2147483647) ? 32'sh7FFFFFFF :
                    (sx < -36'sd2147483648) ? 32'sh80000000 : sx[31:0];
          oy_r   <= (sy > 36'sd2147483647) ? 32'sh7FFFFFFF :
                    (sy < -36'sd2147483648) ? 32'sh80000000 : sy[31:0];
          oa_r   <= sang[14:0];
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = ostb_r;
  assign out_valid        = oval_r;
  assign out_interpolated = oint_r;
  assign out_pos_x        = ox_r;
  assign out_pos_y        = oy_r;
  assign out_angle        = oa_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RING_DEPTH))
    else $error("sample count exceeds ring depth");
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start) || $past(busy)))
    else $error("result strobe without a transaction");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");
  a_scan_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r >= CW'(2)))
    else $error("pair scan with fewer than two samples");
`endif

endmodule
